/* rtl/utf8_to_utf16_decoder_top_defines.svh */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder assertion macros
// Concurrent check helpers shared by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_DECODER_TOP_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define U8U16_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// next-cycle implication
`define U8U16_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`else

`define U8U16_ASSERT_NOW(label, clk, rst, cond, prop)
`define U8U16_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

/* rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Constants and the per-byte run record passed from decode to output stage.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [15:0] ESCAPE_HIGH     = 16'hDBFF;
  localparam logic [15:0] ESCAPE_LOW_BASE = 16'hDE00;
  localparam logic [15:0] SURR_HIGH_BASE  = 16'hD800;
  localparam logic [15:0] SURR_LOW_BASE   = 16'hDC00;
  localparam logic [20:0] SUPP_BASE       = 21'h010000;
  localparam logic [20:0] BMP_MAX         = 21'h00FFFF;

  // escape bytes go out first (two units each), then up to two direct units
  typedef struct packed {
    logic [3:0][7:0]  esc;
    logic [2:0]       esc_cnt;
    logic [1:0][15:0] dir;
    logic [1:0]       dir_cnt;
    logic             last;
  } run_t;

  function automatic logic [3:0] unit_total(input run_t r);
    unit_total = {r.esc_cnt, 1'b0} + {2'b00, r.dir_cnt};
  endfunction

endpackage

/* rtl/u8u16_if.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder stream interfaces
// Valid/ready channels for input bytes and output code units.
// ----------------------------------------------------------------------------
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_of_run;
  logic        end_of_string;

  modport source (output valid, output code_unit, output last_of_run,
                  output end_of_string, input ready);
  modport sink (input valid, input code_unit, input last_of_run,
                input end_of_string, output ready);
endinterface

/* rtl/u8u16_dec.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 byte decoder
// Holds the open sequence and turns one accepted byte into a run record.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_decoder_top_defines.svh"

module u8u16_dec (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output u8u16_pkg::run_t   run,
  output logic              has_units
);

  logic [20:0] acc;
  logic [1:0]  needed;
  logic [1:0]  held_cnt;
  logic [7:0]  held [3];

  logic [20:0] acc_next;
  logic [1:0]  needed_next;
  logic [1:0]  held_cnt_next;
  logic        held_we;
  logic [1:0]  held_idx;

  logic        open_seq, is_cont, is_ascii, lead2, lead3, lead4, is_lead;
  logic        cont_ok, fresh, broken, complete, hold_cont, stray;
  logic        include_held, append_b;
  logic [1:0]  base;
  logic [20:0] cp, supp;

  assign open_seq  = (needed != 2'd0);
  assign is_cont   = (data_byte[7:6] == 2'b10);
  assign is_ascii  = ~data_byte[7];
  assign lead2     = (data_byte[7:5] == 3'b110);
  assign lead3     = (data_byte[7:4] == 4'b1110);
  assign lead4     = (data_byte[7:3] == 5'b11110);
  assign is_lead   = lead2 | lead3 | lead4;
  assign stray     = ~is_ascii & ~is_lead;
  assign cont_ok   = open_seq & is_cont;
  assign fresh     = ~cont_ok;
  assign broken    = open_seq & ~is_cont;
  assign complete  = cont_ok & (needed == 2'd1);
  assign hold_cont = cont_ok & (needed != 2'd1);
  assign cp        = {acc[14:0], data_byte[5:0]};
  assign supp      = cp - u8u16_pkg::SUPP_BASE;

  assign include_held = broken | (hold_cont & last_byte);
  assign append_b     = (fresh & (stray | (is_lead & last_byte))) | (hold_cont & last_byte);
  assign base         = include_held ? held_cnt : 2'd0;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      run.esc[k] = (base == 2'(k)) ? data_byte : held[k];
    end
    run.esc[3]  = data_byte;
    run.esc_cnt = {1'b0, base} + {2'b00, append_b};
    run.last    = last_byte;
    run.dir[1]  = '0;
    run.dir_cnt = 2'd0;
    run.dir[0]  = {8'h00, data_byte};
    if (complete) begin
      if (cp > u8u16_pkg::BMP_MAX) begin
        run.dir[0]  = u8u16_pkg::SURR_HIGH_BASE + {5'b0, supp[20:10]};
        run.dir[1]  = u8u16_pkg::SURR_LOW_BASE | {6'b0, supp[9:0]};
        run.dir_cnt = 2'd2;
      end else begin
        run.dir[0]  = cp[15:0];
        run.dir_cnt = 2'd1;
      end
    end else if (fresh && is_ascii) begin
      run.dir_cnt = 2'd1;
    end
  end

  assign has_units = (run.esc_cnt != 3'd0) || (run.dir_cnt != 2'd0);

  always_comb begin
    acc_next      = acc;
    needed_next   = needed;
    held_cnt_next = held_cnt;
    held_we       = 1'b0;
    held_idx      = held_cnt;
    if (complete) begin
      acc_next      = cp;
      needed_next   = 2'd0;
      held_cnt_next = 2'd0;
    end else if (hold_cont) begin
      acc_next      = cp;
      needed_next   = needed - 2'd1;
      held_we       = (held_cnt != 2'd3);
      held_cnt_next = held_cnt + 2'd1;
    end else if (is_lead) begin
      held_we       = 1'b1;
      held_idx      = 2'd0;
      held_cnt_next = 2'd1;
      if (lead2) begin
        acc_next    = {16'b0, data_byte[4:0]};
        needed_next = 2'd1;
      end else if (lead3) begin
        acc_next    = {17'b0, data_byte[3:0]};
        needed_next = 2'd2;
      end else begin
        acc_next    = {18'b0, data_byte[2:0]};
        needed_next = 2'd3;
      end
    end else begin
      needed_next   = 2'd0;
      held_cnt_next = 2'd0;
    end
    if (last_byte) begin
      acc_next      = '0;
      needed_next   = 2'd0;
      held_cnt_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      needed   <= 2'd0;
      held_cnt <= 2'd0;
    end else if (accept) begin
      acc      <= acc_next;
      needed   <= needed_next;
      held_cnt <= held_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held[held_idx] <= data_byte;
    end
  end

  `U8U16_ASSERT_NOW(a_open_has_lead, clk, rst, (needed != 2'd0), (held_cnt != 2'd0))
  `U8U16_ASSERT_NEXT(a_last_closes, clk, rst, (accept && last_byte),
                     ((needed == 2'd0) && (held_cnt == 2'd0)))
  `U8U16_ASSERT_NOW(a_last_has_units, clk, rst, (accept && last_byte), has_units)

endmodule

/* rtl/u8u16_ser.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 unit serializer
// Registers one run record and sends its code units one per transaction.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_decoder_top_defines.svh"

module u8u16_ser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  u8u16_pkg::run_t       run,
  output logic                  take,
  u8u16_unit_if.source          units
);

  logic            full;
  logic [2:0]      pos;
  logic [3:0]      total;
  u8u16_pkg::run_t run_q;

  logic            final_unit;
  logic [3:0]      esc_units;
  logic [3:0]      dir_pos;

  assign final_unit = (({1'b0, pos} + 4'd1) == total);
  assign take       = ~full | (units.ready & final_unit);
  assign esc_units  = {run_q.esc_cnt, 1'b0};
  assign dir_pos    = {1'b0, pos} - esc_units;

  always_comb begin
    if ({1'b0, pos} < esc_units) begin
      units.code_unit = pos[0]
        ? (u8u16_pkg::ESCAPE_LOW_BASE | {8'h00, run_q.esc[pos[2:1]]})
        : u8u16_pkg::ESCAPE_HIGH;
    end else begin
      units.code_unit = run_q.dir[dir_pos[0]];
    end
  end

  assign units.valid         = full;
  assign units.last_of_run   = final_unit;
  assign units.end_of_string = final_unit & run_q.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      full  <= 1'b0;
      pos   <= 3'd0;
      total <= 4'd0;
    end else if (load) begin
      full  <= 1'b1;
      pos   <= 3'd0;
      total <= u8u16_pkg::unit_total(run);
    end else if (full && units.ready) begin
      if (final_unit) begin
        full <= 1'b0;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_q <= run;
    end
  end

  `U8U16_ASSERT_NOW(a_pos_in_run, clk, rst, full, ({1'b0, pos} < total))
  `U8U16_ASSERT_NOW(a_load_when_free, clk, rst, load, take)
  `U8U16_ASSERT_NEXT(a_load_starts_run, clk, rst, load, (full && (pos == 3'd0)))

endmodule

/* rtl/utf8_to_utf16_decoder_top.sv */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder top level
// Takes one UTF-8 byte per transaction and returns the UTF-16 code units it
// completes. The units a byte causes appear in the next cycle from an output
// register, one unit per cycle while the sink is ready. A plain character
// gives one unit, a supplementary one a surrogate pair, and a byte that
// cannot be decoded the escape pair 0xDBFF, 0xDE00 + byte, so one byte yields
// zero to eight units. The next byte is taken in the same cycle as the last
// unit of the previous run, so the rate is one byte per cycle whenever each
// byte gives at most one unit and the sink is ready; a byte that gives more
// units holds the input until its last unit is taken (single run register).
// last_of_run marks the final unit of each byte and end_of_string the final
// unit of the byte flagged last_byte, after which the decoder is back in its
// reset state.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_top (
  input  logic        clk,
  input  logic        rst,
  u8u16_byte_if.sink  bytes,
  u8u16_unit_if.source units
);

  u8u16_pkg::run_t run;
  logic            has_units;
  logic            take;
  logic            accept;

  assign bytes.ready = take;
  assign accept      = bytes.valid & take;

  u8u16_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (bytes.data_byte),
    .last_byte (bytes.last_byte),
    .run       (run),
    .has_units (has_units)
  );

  u8u16_ser u_ser (
    .clk   (clk),
    .rst   (rst),
    .load  (accept & has_units),
    .run   (run),
    .take  (take),
    .units (units)
  );

endmodule
